// ===== rtl/pure_pursuit_steering_core_defines.svh =====
// assertion macros for the pure pursuit steering core
// expects clk_i and rst_ni in the scope of each use
`ifndef PURE_PURSUIT_STEERING_CORE_DEFINES_SVH
`define PURE_PURSUIT_STEERING_CORE_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
// shared constants, opcodes and cordic angle table for the pure pursuit core
// no dependencies
package pps_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_POINT  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_LOOK_GAIN = 2'd1;
  localparam logic [1:0] REG_MIN_LOOK  = 2'd2;
  localparam logic [1:0] REG_MAX_LOOK  = 2'd3;

  localparam int RadW  = 63;
  localparam int RootW = 32;

  // atan(2^-i) in degrees, q.16
  function automatic logic [22:0] atan_deg(input logic [3:0] i);
    logic [22:0] r;
    case (i)
      4'd0:    r = 23'd2949120;
      4'd1:    r = 23'd1740967;
      4'd2:    r = 23'd919879;
      4'd3:    r = 23'd466945;
      4'd4:    r = 23'd234379;
      4'd5:    r = 23'd117304;
      4'd6:    r = 23'd58666;
      4'd7:    r = 23'd29335;
      4'd8:    r = 23'd14668;
      4'd9:    r = 23'd7334;
      4'd10:   r = 23'd3667;
      4'd11:   r = 23'd1833;
      4'd12:   r = 23'd917;
      4'd13:   r = 23'd458;
      4'd14:   r = 23'd229;
      default: r = 23'd115;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pure_pursuit_steering_core.sv =====
// pure pursuit steering core: sequencer, shared cordic adder, division and state
// uses pps_pkg, pps_mul, pps_isqrt and the assertion macro header
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_ready_o   | opcode, x, y, heading, speed
//  out     | source    | out_valid_o/out_ready_i | steering_deg, found
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// start: 16 heading cordic steps; finish and ignored points leave the sequencer idle
// a point behind ends at the rotation check; a point ahead but nearer than the look-ahead ends at the distance compare
// a point taken runs the 32-step root unit, a 17-step divide and
//   16 vectoring cordic steps (the divide is skipped when the sine saturates)
// reset restores the register and state defaults at once, no clearing pass
// a finish request waits while the sequencer is busy or the output register is full and not taken
`include "pure_pursuit_steering_core_defines.svh"

module pure_pursuit_steering_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [16:0] heading_deg_i,
  input  logic [15:0]        speed_kph_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steering_deg_o,
  output logic               found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TRIG     = 4'd1;
  localparam logic [3:0] S_TRIG_END = 4'd2;
  localparam logic [3:0] S_ROT      = 4'd3;
  localparam logic [3:0] S_CHK      = 4'd4;
  localparam logic [3:0] S_SQ       = 4'd5;
  localparam logic [3:0] S_SQRT     = 4'd6;
  localparam logic [3:0] S_CMP      = 4'd7;
  localparam logic [3:0] S_LOOK     = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_SGN      = 4'd10;
  localparam logic [3:0] S_NUM      = 4'd11;
  localparam logic [3:0] S_VEC      = 4'd12;
  localparam logic [3:0] S_VEC_END  = 4'd13;

  localparam logic signed [41:0] UnitPos  = 42'sd65536;
  localparam logic signed [41:0] UnitNeg  = -42'sd65536;
  localparam logic signed [25:0] SteerPos = 26'sd23040;
  localparam logic signed [25:0] SteerNeg = -26'sd23040;
  localparam logic signed [41:0] CordicK  = 42'sd39797;

  logic [3:0]          state_q;
  logic [4:0]          cnt_q;
  logic [20:0]         wb_q;
  logic [16:0]         gain_q;
  logic [22:0]         minl_q, maxl_q;
  logic signed [31:0]  vx_q, vy_q;
  logic signed [17:0]  hc_q, hs_q;
  logic [15:0]         spd_q;
  logic [22:0]         look_q;
  logic                found_q;
  logic signed [15:0]  steer_q;
  logic                out_valid_q;
  logic signed [15:0]  out_steer_q;
  logic                out_found_q;

  logic signed [32:0]  dx_q, dy_q;
  logic signed [50:0]  acc_q;
  logic signed [34:0]  lx_q, ly_q;
  logic [33:0]         ax_q, ay_q;
  logic [1:0]          k_q;
  logic [61:0]         sq_q;
  logic [34:0]         dist_q;
  logic [50:0]         rem_q, dsh_q;
  logic [16:0]         q_q;
  logic [16:0]         mag_q;
  logic signed [41:0]  cx_q, cy_q;
  logic signed [25:0]  cz_q;
  logic                neg_q;
  logic                vec_q;

  logic                in_acc;
  logic signed [32:0]  ma, mb;
  logic signed [65:0]  prod;
  logic                sq_start;
  logic                sq_done;
  logic [31:0]         sq_root;

  // heading fold
  logic signed [17:0]  h0, h1, h2, h3;
  logic                hneg;

  // cordic datapath
  logic                sig_pos;
  logic signed [41:0]  xsh, ysh, nx, ny;
  logic signed [25:0]  at, nz;

  logic signed [50:0]  p51;
  logic signed [34:0]  ly_abs;
  logic [1:0]          k_d;
  logic [33:0]         axs_full, ays_full;
  logic [24:0]         lk;
  logic [22:0]         lk_cl;
  logic signed [17:0]  sn;
  logic signed [41:0]  xf, yf;
  logic signed [17:0]  xcl, ycl;
  logic signed [25:0]  zr;
  logic signed [15:0]  zcl;

  assign in_ready_o  = (state_q == S_IDLE) &&
                       ((opcode_i != pps_pkg::OP_FINISH) || !out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    h0 = {heading_deg_i[16], heading_deg_i};
    h1 = (h0 >= 18'sd46080) ? h0 - 18'sd92160 : h0;
    h2 = (h1 < -18'sd46080) ? h1 + 18'sd92160 : h1;
    hneg = 1'b0;
    h3 = h2;
    if (h2 > 18'sd23040) begin
      h3   = h2 - 18'sd46080;
      hneg = 1'b1;
    end else if (h2 < -18'sd23040) begin
      h3   = h2 + 18'sd46080;
      hneg = 1'b1;
    end
  end

  always_comb begin
    sig_pos = vec_q ? cy_q[41] : ~cz_q[25];
    xsh = cx_q >>> cnt_q[3:0];
    ysh = cy_q >>> cnt_q[3:0];
    at  = $signed({3'b000, pps_pkg::atan_deg(cnt_q[3:0])});
    if (sig_pos) begin
      nx = cx_q - ysh;
      ny = cy_q + xsh;
      nz = cz_q - at;
    end else begin
      nx = cx_q + ysh;
      ny = cy_q - xsh;
      nz = cz_q + at;
    end
  end

  always_comb begin
    p51      = prod[50:0];
    ly_abs   = ly_q[34] ? -ly_q : ly_q;
    if ((lx_q[33:31] == 3'b000) && (ly_abs[33:31] == 3'b000)) k_d = 2'd0;
    else if ((lx_q[33:32] == 2'b00) && (ly_abs[33:32] == 2'b00)) k_d = 2'd1;
    else if (!lx_q[33] && !ly_abs[33]) k_d = 2'd2;
    else k_d = 2'd3;
    axs_full = ax_q >> k_q;
    ays_full = ay_q >> k_q;
    lk = prod[32:8];
    if (lk < {2'b00, minl_q}) lk_cl = minl_q;
    else if (lk > {2'b00, maxl_q}) lk_cl = maxl_q;
    else lk_cl = lk[22:0];
    sn  = ly_q[34] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    xf  = neg_q ? -cx_q : cx_q;
    yf  = neg_q ? -cy_q : cy_q;
    if (xf > UnitPos) xcl = 18'sd65536;
    else if (xf < UnitNeg) xcl = -18'sd65536;
    else xcl = xf[17:0];
    if (yf > UnitPos) ycl = 18'sd65536;
    else if (yf < UnitNeg) ycl = -18'sd65536;
    else ycl = yf[17:0];
    zr = (cz_q + 26'sd128) >>> 8;
    if (zr > SteerPos) zcl = 16'sd23040;
    else if (zr < SteerNeg) zcl = -16'sd23040;
    else zcl = zr[15:0];
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_ROT: begin
        ma = {{15{(cnt_q[0] ? hs_q[17] : hc_q[17])}}, (cnt_q[0] ? hs_q : hc_q)};
        mb = (cnt_q == 5'd0 || cnt_q == 5'd3) ? dx_q : dy_q;
      end
      S_SQ: begin
        ma = (cnt_q == 5'd0) ? $signed({2'b00, axs_full[30:0]})
                             : $signed({2'b00, ays_full[30:0]});
        mb = ma;
      end
      S_CMP: begin
        ma = $signed({17'd0, spd_q});
        mb = $signed({16'd0, gain_q});
      end
      S_SGN: begin
        ma = $signed({11'd0, wb_q, 1'b0});
        mb = {{15{sn[17]}}, sn};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  pps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  assign sq_start = (state_q == S_SQ) && (cnt_q == 5'd2);

  pps_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ({1'b0, sq_q} + {1'b0, prod[61:0]}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wb_q        <= 21'd127795;
      gain_q      <= 17'd62259;
      minl_q      <= 23'd131072;
      maxl_q      <= 23'd1966080;
      vx_q        <= '0;
      vy_q        <= '0;
      hc_q        <= 18'sd65536;
      hs_q        <= '0;
      spd_q       <= '0;
      look_q      <= 23'd327680;
      found_q     <= 1'b0;
      steer_q     <= '0;
      out_valid_q <= 1'b0;
      out_steer_q <= '0;
      out_found_q <= 1'b0;
      vec_q       <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pps_pkg::REG_WHEELBASE: wb_q   <= cfg_data_i[20:0];
          pps_pkg::REG_LOOK_GAIN: gain_q <= cfg_data_i[16:0];
          pps_pkg::REG_MIN_LOOK:  minl_q <= cfg_data_i;
          default:                maxl_q <= cfg_data_i;
        endcase
      end

      if (in_acc && opcode_i == pps_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
        out_steer_q <= found_q ? steer_q : 16'sd0;
        out_found_q <= found_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && opcode_i == pps_pkg::OP_START) begin
            vx_q    <= x_coord_i;
            vy_q    <= y_coord_i;
            spd_q   <= speed_kph_i;
            found_q <= 1'b0;
            neg_q   <= hneg;
            vec_q   <= 1'b0;
            cnt_q   <= '0;
            state_q <= S_TRIG;
          end else if (in_acc && opcode_i == pps_pkg::OP_POINT && !found_q) begin
            cnt_q   <= '0;
            state_q <= S_ROT;
          end
        end
        S_TRIG: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) state_q <= S_TRIG_END;
        end
        S_TRIG_END: begin
          hc_q    <= xcl;
          hs_q    <= ycl;
          state_q <= S_IDLE;
        end
        S_ROT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd4) state_q <= S_CHK;
        end
        S_CHK: begin
          cnt_q   <= '0;
          state_q <= (lx_q[34] || lx_q == '0) ? S_IDLE : S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) state_q <= S_CMP;
        end
        S_CMP: begin
          state_q <= (dist_q < {12'd0, look_q}) ? S_IDLE : S_LOOK;
        end
        S_LOOK: begin
          look_q  <= lk_cl;
          cnt_q   <= '0;
          state_q <= ({2'b00, ay_q} >= {dist_q, 1'b0}) ? S_SGN : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) state_q <= S_SGN;
        end
        S_SGN: begin
          state_q <= S_NUM;
        end
        S_NUM: begin
          vec_q   <= 1'b1;
          neg_q   <= 1'b0;
          cnt_q   <= '0;
          state_q <= S_VEC;
        end
        S_VEC: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) state_q <= S_VEC_END;
        end
        S_VEC_END: begin
          steer_q <= zcl;
          found_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == pps_pkg::OP_START) begin
      cx_q <= CordicK;
      cy_q <= '0;
      cz_q <= {h3, 8'd0};
    end
    if (in_acc && opcode_i == pps_pkg::OP_POINT) begin
      dx_q <= {x_coord_i[31], x_coord_i} - {vx_q[31], vx_q};
      dy_q <= {y_coord_i[31], y_coord_i} - {vy_q[31], vy_q};
    end
    if (state_q == S_TRIG || state_q == S_VEC) begin
      cx_q <= nx;
      cy_q <= ny;
      cz_q <= nz;
    end
    if (state_q == S_ROT) begin
      if (cnt_q == 5'd1 || cnt_q == 5'd3) acc_q <= p51;
      if (cnt_q == 5'd2) lx_q <= 35'((acc_q + p51) >>> 16);
      if (cnt_q == 5'd4) ly_q <= 35'((acc_q - p51) >>> 16);
    end
    if (state_q == S_CHK) begin
      ax_q <= lx_q[33:0];
      ay_q <= ly_abs[33:0];
      k_q  <= k_d;
    end
    if (state_q == S_SQ && cnt_q == 5'd1) sq_q <= prod[61:0];
    if (state_q == S_SQRT && sq_done) dist_q <= {3'b000, sq_root} << k_q;
    if (state_q == S_LOOK) begin
      rem_q <= {1'b0, ay_q, 16'd0};
      dsh_q <= {dist_q, 16'd0};
      q_q   <= '0;
      mag_q <= 17'd65536;
    end
    if (state_q == S_DIV) begin
      dsh_q <= dsh_q >> 1;
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        q_q   <= {q_q[15:0], 1'b1};
      end else begin
        q_q <= {q_q[15:0], 1'b0};
      end
      if (cnt_q == 5'd16) begin
        mag_q <= (rem_q >= dsh_q) ? ((q_q[15:0] == 16'hffff && q_q[16]) ? 17'd65536 :
                 ({q_q[15:0], 1'b1} > 17'd65536 ? 17'd65536 : {q_q[15:0], 1'b1}))
               : ({q_q[15:0], 1'b0} > 17'd65536 ? 17'd65536 : {q_q[15:0], 1'b0});
      end
    end
    if (state_q == S_SGN) cx_q <= {3'b000, look_q, 16'd0};
    if (state_q == S_NUM) begin
      cy_q <= prod[41:0];
      cz_q <= '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign steering_deg_o = out_steer_q;
  assign found_o        = out_found_q;

  `PPS_ASSERT_IMP(a_nofound_zero, out_valid_o && !found_o, steering_deg_o == 16'sd0,
    "steering nonzero without a found point")
  `PPS_ASSERT_IMP(a_steer_range, found_q, (steer_q <= 16'sd23040) && (steer_q >= -16'sd23040),
    "held steering out of range")
  `PPS_ASSERT_NXT(a_finish_emits, in_valid_i && in_ready_o && opcode_i == pps_pkg::OP_FINISH,
    out_valid_o, "finish request gave no result")

endmodule

// ===== rtl/pps_mul.sv =====
// shared registered signed multiplier, 33 x 33 bits
// no package dependencies
module pps_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/pps_isqrt.sv =====
// bit-serial integer square root, one root bit per cycle
// uses pps_pkg for radicand and root widths
module pps_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pps_pkg::RadW-1:0]   rad_i,
  output logic                       done_o,
  output logic [pps_pkg::RootW-1:0]  root_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [4:0]                 cnt_q;
  logic [63:0]                rad_q;
  logic [33:0]                rem_q;
  logic [pps_pkg::RootW-1:0]  root_q;
  logic [35:0]                sh;
  logic [35:0]                trial;
  logic [35:0]                diff;

  assign sh    = {rem_q, rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (sh >= trial) begin
        rem_q  <= diff[33:0];
        root_q <= {root_q[pps_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= sh[33:0];
        root_q <= {root_q[pps_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
